// ===== rtl/core/lsrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_pkg
// Shared types, constants and the rotation angle table for the lidar scan
// reflector detector.
// ----------------------------------------------------------------------------
package lsrd_pkg;

    localparam int MAX_SAMPLES     = 2048;
    localparam int ROTATE_STAGES   = 16;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int ROT_STEPS       = (ROTATE_STAGES < ANGLE_TABLE_LEN) ?
                                     ROTATE_STAGES : ANGLE_TABLE_LEN;
    localparam int TAB_IDX_W       = $clog2(ANGLE_TABLE_LEN);

    localparam int DATA_W   = 16;
    localparam int COUNT_W  = 12;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_CAP = (MAX_SAMPLES < 4095) ? MAX_SAMPLES : 4095;

    // Rotation datapath widths: x and y carry r * 2^16 plus headroom.
    localparam int XY_W = 35;
    localparam int Z_W  = 33;

    localparam logic [31:0] GAIN_Q16  = 32'd39797;
    localparam logic [19:0] POS_LIMIT = 20'd65535;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP   = 2'd3;

    localparam logic [31:0] ANGLE_TABLE [ANGLE_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_ROTATE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic take;      // a sample word is accepted this cycle
        logic rot_init;  // load the rotation registers from the captured point
        logic rot_step;  // perform one micro-rotation
        logic out_load;  // move the finished result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last; // the current micro-rotation is the final one
    } t_dp_status;

endpackage

// ===== rtl/core/lidar_scan_reflector_detect_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_reflector_detect_core
// Counts high-intensity and near high-intensity lidar returns per scan and
// reports the Cartesian position of the first high-intensity return.
// Throughput: one sample word per cycle within a scan. After the last word of
// a scan no word is taken while the core loads the rotator, runs the 16 CORDIC
// micro-rotations and loads the output register. The result word is valid once
// the output register is loaded; that load waits while the previous result word
// is still waiting.
// Reset (synchronous, active low) restores the default configuration and
// clears all scan state and the output valid flag.
// ----------------------------------------------------------------------------
module lidar_scan_reflector_detect_core
    import lsrd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_W-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [DATA_W-1:0]       i_intensity,
    input  logic [DATA_W-1:0]       i_range_mm,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [COUNT_W-1:0]      o_high_count,
    output logic [COUNT_W-1:0]      o_near_high_count,
    output logic                    o_found,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y
);

    t_dp_cmd    cmd;
    t_dp_status status;

    lsrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lsrd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_intensity       (i_intensity),
        .i_range_mm        (i_range_mm),
        .i_last            (i_last),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_high_count      (o_high_count),
        .o_near_high_count (o_near_high_count),
        .o_found           (o_found),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y)
    );

endmodule

// ===== rtl/core/lsrd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_ctrl
// Sequencer: accepts sample words, runs the rotation after the last word of
// a scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module lsrd_ctrl
    import lsrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        // A delivered word frees the output register.
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.rot_init = 1'b1;
                n_state        = S_ROTATE;
            end
            S_ROTATE: begin
                o_cmd.rot_step = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/lsrd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_datapath
// Configuration registers, per-scan counters and capture, an iterative
// CORDIC rotator and the output register.
// ----------------------------------------------------------------------------
module lsrd_datapath
    import lsrd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data,
    input  logic [DATA_W-1:0]           i_intensity,
    input  logic [DATA_W-1:0]           i_range_mm,
    input  logic                        i_last,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    output logic [COUNT_W-1:0]          o_high_count,
    output logic [COUNT_W-1:0]          o_near_high_count,
    output logic                        o_found,
    output logic signed [POS_W-1:0]     o_pos_x,
    output logic signed [POS_W-1:0]     o_pos_y
);

    // Rounds a Q16 value half away from zero and clamps it to the position range.
    function automatic logic signed [POS_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        logic              neg;
        logic [XY_W-1:0]   mag;
        logic [XY_W:0]     sum;
        logic [19:0]       q;
        logic [POS_W-1:0]  m;
        neg = v[XY_W-1];
        mag = neg ? (~v + 1'b1) : v;
        sum = {1'b0, mag} + (XY_W+1)'(32768);
        q   = sum[XY_W:16];
        m   = (q > POS_LIMIT) ? POS_W'(POS_LIMIT) : POS_W'(q);
        return neg ? $signed(~m + 1'b1) : $signed(m);
    endfunction

    // Configuration.
    logic [DATA_W-1:0] r_threshold, r_near_limit, r_start_ang, r_ang_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= DATA_W'(128);
            r_near_limit <= DATA_W'(300);
            r_start_ang  <= '0;
            r_ang_step   <= DATA_W'(91);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                CFG_NEAR_LIMIT: r_near_limit <= i_cfg_data;
                CFG_START_ANG:  r_start_ang  <= i_cfg_data;
                CFG_ANG_STEP:   r_ang_step   <= i_cfg_data;
            endcase
        end
    end

    // Scan state.
    logic [INDEX_W-1:0] r_index;
    logic [COUNT_W-1:0] r_high, r_near;
    logic               r_seen;
    logic [DATA_W-1:0]  r_first_range, r_first_ang;

    logic [COUNT_W-1:0] n_high, n_near;
    logic               n_seen;
    logic [DATA_W-1:0]  n_first_range, n_first_ang;
    logic               is_high, is_near;
    logic [INDEX_W+DATA_W-1:0] ang_prod;
    logic [DATA_W-1:0]  beam_ang;

    assign is_high  = i_intensity > r_threshold;
    assign is_near  = i_range_mm < r_near_limit;
    // Only the low 16 bits of the product matter, so signedness of the step is moot.
    assign ang_prod = r_index * r_ang_step;
    assign beam_ang = r_start_ang + ang_prod[DATA_W-1:0];

    always_comb begin
        n_high        = r_high;
        n_near        = r_near;
        n_seen        = r_seen;
        n_first_range = r_first_range;
        n_first_ang   = r_first_ang;
        if (is_high) begin
            if (r_high < COUNT_W'(COUNT_CAP)) begin
                n_high = r_high + 1'b1;
            end
            if (is_near && r_near < COUNT_W'(COUNT_CAP)) begin
                n_near = r_near + 1'b1;
            end
            if (!r_seen) begin
                n_seen        = 1'b1;
                n_first_range = i_range_mm;
                n_first_ang   = beam_ang;
            end
        end
    end

    // Result held for the rotation and output stages.
    logic [COUNT_W-1:0] r_res_high, r_res_near;
    logic               r_res_found;
    logic [DATA_W-1:0]  r_res_range, r_res_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index       <= '0;
            r_high        <= '0;
            r_near        <= '0;
            r_seen        <= 1'b0;
            r_first_range <= '0;
            r_first_ang   <= '0;
        end else if (i_cmd.take) begin
            if (i_last) begin
                r_index       <= '0;
                r_high        <= '0;
                r_near        <= '0;
                r_seen        <= 1'b0;
                r_first_range <= '0;
                r_first_ang   <= '0;
            end else begin
                r_index       <= r_index + 1'b1;
                r_high        <= n_high;
                r_near        <= n_near;
                r_seen        <= n_seen;
                r_first_range <= n_first_range;
                r_first_ang   <= n_first_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_last) begin
            r_res_high  <= n_high;
            r_res_near  <= n_near;
            r_res_found <= n_seen;
            r_res_range <= n_first_range;
            r_res_ang   <= n_first_ang;
        end
    end

    // Iterative CORDIC in rotation mode, one micro-rotation per cycle.
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [TAB_IDX_W-1:0]   r_iter;

    logic [31:0]            init_prod;
    logic signed [XY_W-1:0] init_x, dx, dy;
    logic                   fold;
    logic signed [Z_W-1:0]  init_z, step_ang;

    assign init_prod = r_res_range * GAIN_Q16[DATA_W-1:0];
    // Angles outside [-pi/2, pi/2) are turned by pi with the start vector negated.
    assign fold      = r_res_ang[DATA_W-1] ^ r_res_ang[DATA_W-2];
    assign init_x    = fold ? -$signed(XY_W'(init_prod)) : $signed(XY_W'(init_prod));
    assign init_z    = $signed({{(Z_W-DATA_W-16){r_res_ang[DATA_W-1] ^ fold}},
                                r_res_ang[DATA_W-1] ^ fold,
                                r_res_ang[DATA_W-2:0], 16'b0});
    assign dx        = r_y >>> r_iter;
    assign dy        = r_x >>> r_iter;
    assign step_ang  = $signed(Z_W'(ANGLE_TABLE[r_iter]));

    assign o_status.iter_last = (r_iter == TAB_IDX_W'(ROT_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_init) begin
            r_x    <= init_x;
            r_y    <= '0;
            r_z    <= init_z;
            r_iter <= '0;
        end else if (i_cmd.rot_step) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - step_ang;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + step_ang;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    // Output register.
    logic [COUNT_W-1:0]      r_o_high, r_o_near;
    logic                    r_o_found;
    logic signed [POS_W-1:0] r_o_x, r_o_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_high  <= r_res_high;
            r_o_near  <= r_res_near;
            r_o_found <= r_res_found;
            r_o_x     <= r_res_found ? round_sat(r_x) : '0;
            r_o_y     <= r_res_found ? round_sat(r_y) : '0;
        end
    end

    assign o_high_count      = r_o_high;
    assign o_near_high_count = r_o_near;
    assign o_found           = r_o_found;
    assign o_pos_x           = r_o_x;
    assign o_pos_y           = r_o_y;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar scan reflector detector. Scan samples
// are driven over a valid/ready channel with random gaps. A bench-side model
// of the counters and the CORDIC rotation predicts each end-of-scan summary
// word, which is checked field by field as it leaves the core. The run
// covers default and extreme settings, quadrant boundaries, output back
// pressure and longer scans whose first reflector arrives late.
// ----------------------------------------------------------------------------
module tb_top;
    import lsrd_pkg::*;

    localparam int     SETTLE_CYCLES   = 25;
    localparam longint CORDIC_GAIN_Q16 = 39797;
    localparam longint POS_MAX         = 65535;

    localparam logic [31:0] ATAN_Q31 [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_xy;

    typedef struct packed {
        logic [COUNT_W-1:0]      high_count;
        logic [COUNT_W-1:0]      near_count;
        logic                    found;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_scan_summary;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0]     i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [DATA_W-1:0]     i_intensity = '0;
    logic [DATA_W-1:0]     i_range_mm  = '0;
    logic                  i_last      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [COUNT_W-1:0]    o_high_count;
    logic [COUNT_W-1:0]    o_near_high_count;
    logic                  o_found;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;

    lidar_scan_reflector_detect_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_intensity       (i_intensity),
        .i_range_mm        (i_range_mm),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_high_count      (o_high_count),
        .o_near_high_count (o_near_high_count),
        .o_found           (o_found),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y)
    );

    // Bench copy of the configuration and the per-scan state.
    logic [15:0]          cfg_threshold = 16'd128;
    logic [15:0]          cfg_near_limit = 16'd300;
    logic [15:0]          cfg_start_angle = 16'd0;
    logic [15:0]          cfg_angle_step = 16'd91;
    logic [INDEX_W-1:0]   beam_index = '0;
    logic [COUNT_W-1:0]   high_total = '0;
    logic [COUNT_W-1:0]   near_total = '0;
    logic                 first_seen = 1'b0;
    logic [15:0]          first_range = '0;
    logic [15:0]          first_angle = '0;

    t_scan_summary expected_summaries [$];

    int unsigned error_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned scans_checked  = 0;
    int unsigned reg_writes     = 0;

    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit offering     = 1'b0;
    int pending_gap  = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int rx_phase_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: summary words still pending: %0d", expected_summaries.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_error($sformatf("scan %0d %s: got %0d, expected %0d",
                                   scans_checked, name, got, want));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [POS_W-1:0] round_q16(input longint v);
        longint m;
        if (v >= 0)
            m = (v + 32768) >>> 16;
        else
            m = -((-v + 32768) >>> 16);
        if (m > POS_MAX)
            m = POS_MAX;
        if (m < -POS_MAX)
            m = -POS_MAX;
        return m[POS_W-1:0];
    endfunction

    // Polar to Cartesian by CORDIC on a 32-bit binary angle.
    function automatic t_xy rotate_to_xy(input logic [15:0] r, input logic [15:0] ang);
        longint      x;
        longint      y;
        longint      zs;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        logic [31:0] zq;
        t_xy         p;
        x  = longint'(r) * CORDIC_GAIN_Q16;
        y  = 0;
        z  = {ang, 16'h0000};
        zq = z + 32'h4000_0000;
        // Outside the right half plane the vector is flipped and the angle turned by pi.
        if (zq[31]) begin
            z = z + 32'h8000_0000;
            x = -x;
        end
        zs = longint'($signed(z));
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (zs >= 0) begin
                x  = x - dx;
                y  = y + dy;
                zs = zs - longint'(ATAN_Q31[i]);
            end else begin
                x  = x + dx;
                y  = y - dy;
                zs = zs + longint'(ATAN_Q31[i]);
            end
        end
        p.x = round_q16(x);
        p.y = round_q16(y);
        return p;
    endfunction

    task automatic predict_sample(input logic [15:0] inten, input logic [15:0] rng,
                                  input logic lst);
        t_scan_summary s;
        t_xy           p;
        if (inten > cfg_threshold) begin
            if (high_total < COUNT_CAP)
                high_total = high_total + 1'b1;
            if (rng < cfg_near_limit && near_total < COUNT_CAP)
                near_total = near_total + 1'b1;
            if (!first_seen) begin
                first_seen  = 1'b1;
                first_range = rng;
                first_angle = cfg_start_angle + beam_index * cfg_angle_step;
            end
        end
        beam_index = beam_index + 1'b1;
        if (lst) begin
            p = '0;
            if (first_seen)
                p = rotate_to_xy(first_range, first_angle);
            s.high_count = high_total;
            s.near_count = near_total;
            s.found      = first_seen;
            s.pos_x      = p.x;
            s.pos_y      = p.y;
            expected_summaries.push_back(s);
            beam_index  = '0;
            high_total  = '0;
            near_total  = '0;
            first_seen  = 1'b0;
            first_range = '0;
            first_angle = '0;
        end
    endtask

    // Offers one sample word and returns at the edge where it is taken. Valid is
    // left high only when the next word follows straight away.
    task automatic send_sample(input logic [15:0] inten, input logic [15:0] rng,
                               input logic lst);
        if (pending_gap > 0)
            repeat (pending_gap) @(posedge i_clk);
        i_in_valid  <= 1'b1;
        i_intensity <= inten;
        i_range_mm  <= rng;
        i_last      <= lst;
        offering     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_sample(inten, rng, lst);
        samples_sent++;
        pending_gap = tx_idle ? pick_gap() : 0;
        if (pending_gap > 0) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
        end
    endtask

    task automatic stop_offering();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
            @(posedge i_clk);
        end
        pending_gap = 0;
    endtask

    task automatic wait_scans_done();
        stop_offering();
        while (expected_summaries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] thr, input logic [15:0] near_lim,
                             input logic [15:0] start_ang, input logic [15:0] step);
        logic [15:0] vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{thr, near_lim, start_ang, step};
        idx  = '{CFG_THRESHOLD, CFG_NEAR_LIMIT, CFG_START_ANG, CFG_ANG_STEP};
        wait_scans_done();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            reg_writes++;
        end
        i_cfg_we <= 1'b0;
        cfg_threshold   = thr;
        cfg_near_limit  = near_lim;
        cfg_start_angle = start_ang;
        cfg_angle_step  = step;
    endtask

    function automatic logic [15:0] near_value(input logic [15:0] pivot);
        case ($urandom_range(0, 7))
            0:       return pivot;
            1:       return pivot + 16'd1;
            2:       return pivot - 16'd1;
            3:       return 16'h0000;
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_setting(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_scan(input int len);
        for (int k = 0; k < len; k++)
            send_sample(near_value(cfg_threshold), near_value(cfg_near_limit), k == len - 1);
    endtask

    // Receiver: checks each summary word taken and drives ready.
    always @(posedge i_clk) begin : summary_check
        t_scan_summary want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_summaries.size() == 0) begin
                report_error("summary word with no scan pending");
            end else begin
                want = expected_summaries.pop_front();
                check_field("high_count", o_high_count, want.high_count);
                check_field("near_high_count", o_near_high_count, want.near_count);
                check_field("found", o_found, want.found);
                check_field("pos_x", o_pos_x, want.pos_x);
                check_field("pos_y", o_pos_y, want.pos_y);
                scans_checked++;
            end
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left    = hold_left - 1;
        end else if (rx_phase_left > 0) begin
            rx_phase_left = rx_phase_left - 1;
        end else if (rx_idle && $urandom_range(0, 2) == 0) begin
            i_out_ready  <= 1'b0;
            rx_phase_left = pick_gap();
        end else begin
            i_out_ready  <= 1'b1;
            rx_phase_left = $urandom_range(0, 6);
        end
    end

    task automatic test_directed_cases();
        logic [15:0] quad_angles [6];
        quad_angles = '{16'h4000, 16'h3FFF, 16'hC000, 16'hBFFF, 16'h8000, 16'h7FFF};
        // Reset settings: intensity equal to the threshold does not count.
        send_sample(16'd128, 16'd500, 1'b0);
        send_sample(16'd0, 16'd0, 1'b1);
        // First high word at index one; range equal to the limit is not near.
        send_sample(16'd100, 16'd10, 1'b0);
        send_sample(16'd129, 16'd299, 1'b0);
        send_sample(16'hFFFF, 16'd300, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b1);
        // Full-scale range on the x axis saturates.
        send_sample(16'hFFFF, 16'hFFFF, 1'b1);
        send_sample(16'd200, 16'd0, 1'b1);
        // Angles on and just beside the quadrant boundaries.
        for (int k = 0; k < 6; k++) begin
            configure(16'd0, 16'hFFFF, quad_angles[k], 16'd0);
            send_sample(16'd1, (k % 2) ? 16'd40000 : 16'hFFFF, 1'b1);
        end
        // Extreme steps: index two with a half-turn step wraps back to zero.
        configure(16'd0, 16'h1000, 16'd0, 16'h8000);
        send_sample(16'd0, 16'h0001, 1'b0);
        send_sample(16'd0, 16'h0002, 1'b0);
        send_sample(16'hFFFF, 16'h0FFF, 1'b1);
        configure(16'd0, 16'd0, 16'h8000, 16'h7FFF);
        send_sample(16'd0, 16'd5, 1'b0);
        send_sample(16'd1, 16'hABCD, 1'b1);
        wait_scans_done();
    endtask

    task automatic test_random_scans();
        int phase_items;
        int len;
        int r;
        for (int ph = 0; ph < 12; ph++) begin
            configure(pick_setting(16'h0000, 16'hFFFF), pick_setting(16'h0000, 16'hFFFF),
                      pick_setting(16'h8000, 16'h7FFF), pick_setting(16'h8000, 16'h7FFF));
            tx_idle = (ph % 4) != 3;
            rx_idle = (ph % 4) != 3;
            phase_items = 0;
            while (phase_items < 60) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 12);
                else if (r < 95)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(61, 200);
                send_random_scan(len);
                phase_items += len;
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_scans_done();
    endtask

    task automatic test_output_backpressure();
        configure(16'd0, 16'd1000, 16'($urandom_range(0, 65535)), 16'd91);
        tx_idle = 1'b0;
        hold_request = 400;
        // The receiver is held off while short scans keep arriving, so the core
        // must stop taking words until the summaries drain.
        for (int k = 0; k < 30; k++)
            send_random_scan($urandom_range(1, 3));
        tx_idle = 1'b1;
        wait_scans_done();
    endtask

    task automatic test_long_scans();
        tx_idle = 1'b0;
        // Every word high and near, so both counters climb on every word.
        configure(16'd0, 16'hFFFF, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        for (int k = 0; k < 120; k++)
            send_sample(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65534)),
                        k == 119);
        // First high word arrives late in the scan.
        configure(16'h0100, 16'h8000, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        for (int k = 0; k < 50; k++)
            send_sample(16'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b0);
        for (int k = 0; k < 10; k++)
            send_sample(16'($urandom_range(257, 65535)), 16'($urandom_range(0, 65535)),
                        k == 9);
        tx_idle = 1'b1;
        wait_scans_done();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_scans();
        test_output_backpressure();
        test_long_scans();
        wait_scans_done();
        $display("Summary: %0d sample words, %0d scan summaries checked, %0d register writes.",
                 samples_sent, scans_checked, reg_writes);
        $display("Covered default and extreme settings, quadrant edges, output stalls and longer scans.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches reported", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
